/* hw/rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types, constants and helpers shared by the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int          RESULT_FIFO_DEPTH = 4;

    localparam logic [15:0] HI_SURROGATE_BASE = 16'hD800;
    localparam logic [15:0] LO_SURROGATE_BASE = 16'hDC00;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
    localparam logic [20:0] SURROGATE_FIRST   = 21'd55296;
    localparam logic [20:0] SURROGATE_LAST    = 21'd57343;
    localparam logic [20:0] CODE_POINT_MAX    = 21'd1114111;
    localparam logic [20:0] TWO_BYTE_MIN      = 21'd128;
    localparam logic [20:0] THREE_BYTE_MIN    = 21'd2048;
    localparam logic [15:0] UNIT_TOTAL_MAX    = 16'hFFFF;

    localparam logic [7:0]  CONT_MASK         = 8'hC0;
    localparam logic [7:0]  CONT_TAG          = 8'h80;
    localparam logic [7:0]  CONT_BITS         = 8'h3F;

    // Number of continuation bytes a sequence still expects or started with.
    localparam logic [1:0]  CONTS_NONE        = 2'd0;
    localparam logic [1:0]  CONTS_ONE         = 2'd1;
    localparam logic [1:0]  CONTS_TWO         = 2'd2;
    localparam logic [1:0]  CONTS_THREE       = 2'd3;

    // One output request.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        string_end;
        logic        bad_input;
        logic [15:0] unit_total;
    } t_result;

    // Results produced by one input byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_step;

    function automatic logic [15:0] sat_inc(input logic [15:0] value);
        sat_inc = (value == UNIT_TOTAL_MAX) ? value : value + 16'd1;
    endfunction

endpackage

/* hw/rtl/u8u16_in_if.sv */
// ----------------------------------------------------------------------------
// u8u16_in_if
// Byte channel into the transcoder: valid, ready and one UTF-8 byte.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

/* hw/rtl/u8u16_out_if.sv */
// ----------------------------------------------------------------------------
// u8u16_out_if
// Result channel out of the transcoder: valid, ready and one result.
// ----------------------------------------------------------------------------
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_end;
    logic        bad_input;
    logic [15:0] unit_total;

    modport source (output valid, output code_unit, output unit_valid,
                    output string_end, output bad_input, output unit_total,
                    input ready);
    modport sink   (input valid, input code_unit, input unit_valid,
                    input string_end, input bad_input, input unit_total,
                    output ready);
endinterface

/* hw/rtl/u8u16_decoder.sv */
// ----------------------------------------------------------------------------
// u8u16_decoder
// Strict UTF-8 decode state and the per-byte update that yields up to two
// UTF-16 results.
// ----------------------------------------------------------------------------
module u8u16_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step_en,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output u8u16_pkg::t_step  o_step
);
    import u8u16_pkg::*;

    logic [1:0]  r_pend, n_pend;
    logic [20:0] r_point, n_point;
    logic [1:0]  r_seq, n_seq;
    logic        r_err, n_err;
    logic [15:0] r_total, n_total;

    logic        have_point;
    logic [20:0] point;
    logic [20:0] shifted;
    logic [19:0] offset;
    logic [15:0] total_one;
    logic [15:0] total_two;
    logic        in_range;

    assign shifted   = {r_point[14:0], i_byte[5:0]};
    assign total_one = sat_inc(r_total);
    assign total_two = sat_inc(total_one);
    assign offset    = 20'(point - SUPPLEMENTARY_BASE);

    always_comb begin
        n_pend     = r_pend;
        n_point    = r_point;
        n_seq      = r_seq;
        n_err      = r_err;
        n_total    = r_total;
        have_point = 1'b0;
        point      = '0;
        in_range   = 1'b0;

        if (!r_err) begin
            if (r_pend == CONTS_NONE) begin
                if (!i_byte[7]) begin
                    have_point = 1'b1;
                    point      = {13'd0, i_byte};
                end else if (i_byte[7:5] == 3'b110) begin
                    n_pend  = CONTS_ONE;
                    n_seq   = CONTS_ONE;
                    n_point = {16'd0, i_byte[4:0]};
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_pend  = CONTS_TWO;
                    n_seq   = CONTS_TWO;
                    n_point = {17'd0, i_byte[3:0]};
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_pend  = CONTS_THREE;
                    n_seq   = CONTS_THREE;
                    n_point = {18'd0, i_byte[2:0]};
                end else begin
                    n_err = 1'b1;
                end
            end else if ((i_byte & CONT_MASK) != CONT_TAG) begin
                n_err = 1'b1;
            end else begin
                n_point = shifted;
                n_pend  = r_pend - 2'd1;
                if (r_pend == CONTS_ONE) begin
                    // The sequence is complete: check for overlong forms,
                    // surrogates and values past the last code point.
                    unique case (r_seq)
                        CONTS_ONE:   in_range = shifted >= TWO_BYTE_MIN;
                        CONTS_TWO:   in_range = shifted >= THREE_BYTE_MIN &&
                                                (shifted < SURROGATE_FIRST ||
                                                 shifted > SURROGATE_LAST);
                        default:     in_range = shifted >= SUPPLEMENTARY_BASE &&
                                                shifted <= CODE_POINT_MAX;
                    endcase
                    if (in_range) begin
                        have_point = 1'b1;
                        point      = shifted;
                    end else begin
                        n_err = 1'b1;
                    end
                    n_point = '0;
                    n_seq   = CONTS_NONE;
                end
            end
        end

        // A character cut off by the end of the string is an error.
        if (i_last && !n_err && n_pend != CONTS_NONE) begin
            n_err = 1'b1;
        end

        o_step = '0;
        if (have_point) begin
            if (point < SUPPLEMENTARY_BASE) begin
                o_step.count  = 2'd1;
                o_step.first  = '{code_unit: point[15:0], unit_valid: 1'b1,
                                  string_end: i_last, bad_input: n_err,
                                  unit_total: total_one};
                n_total       = total_one;
            end else begin
                o_step.count  = 2'd2;
                o_step.first  = '{code_unit: HI_SURROGATE_BASE | {6'd0, offset[19:10]},
                                  unit_valid: 1'b1, string_end: 1'b0,
                                  bad_input: n_err, unit_total: total_one};
                o_step.second = '{code_unit: LO_SURROGATE_BASE | {6'd0, offset[9:0]},
                                  unit_valid: 1'b1, string_end: i_last,
                                  bad_input: n_err, unit_total: total_two};
                n_total       = total_two;
            end
        end else if (i_last) begin
            o_step.count = 2'd1;
            o_step.first = '{code_unit: 16'd0, unit_valid: 1'b0, string_end: 1'b1,
                             bad_input: n_err, unit_total: r_total};
        end

        // The end of a string returns the decoder to its reset state.
        if (i_last) begin
            n_pend  = CONTS_NONE;
            n_point = '0;
            n_seq   = CONTS_NONE;
            n_err   = 1'b0;
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= CONTS_NONE;
            r_point <= '0;
            r_seq   <= CONTS_NONE;
            r_err   <= 1'b0;
            r_total <= '0;
        end else if (i_step_en) begin
            r_pend  <= n_pend;
            r_point <= n_point;
            r_seq   <= n_seq;
            r_err   <= n_err;
            r_total <= n_total;
        end
    end

endmodule

/* hw/rtl/u8u16_fifo.sv */
// ----------------------------------------------------------------------------
// u8u16_fifo
// Result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module u8u16_fifo #(
    parameter int DEPTH = u8u16_pkg::RESULT_FIFO_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u8u16_pkg::t_step    i_step,
    output logic                o_room,
    output logic                o_valid,
    output u8u16_pkg::t_result  o_data,
    input  logic                i_pop
);
    import u8u16_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_level, n_level;
    logic [PW-1:0] wr_next;
    logic [1:0]    push_cnt;
    logic          pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
        wrap_inc = (ptr == LAST_SLOT) ? '0 : ptr + PW'(1);
    endfunction

    assign wr_next  = wrap_inc(r_wr);
    assign push_cnt = i_push ? i_step.count : 2'd0;
    assign pop      = i_pop && (r_level != '0);

    // Room is reserved for a surrogate pair before a byte is taken.
    assign o_room  = r_level <= ROOM_LIMIT;
    assign o_valid = r_level != '0;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_rd    = pop ? wrap_inc(r_rd) : r_rd;
        n_wr    = r_wr;
        if (push_cnt == 2'd1) begin
            n_wr = wr_next;
        end else if (push_cnt == 2'd2) begin
            n_wr = wrap_inc(wr_next);
        end
        n_level = r_level + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_step.first;
        end
        if (push_cnt == 2'd2) begin
            r_mem[wr_next] <= i_step.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

endmodule

/* hw/rtl/strict_utf8_to_utf16.sv */
// ----------------------------------------------------------------------------
// strict_utf8_to_utf16
// Strict streaming UTF-8 to UTF-16 transcoder with end-of-string status.
//
//   Channel  Dir  Payload                                            Per request
//   i_in     in   in_byte[7:0], is_last                              one byte
//   o_out    out  code_unit[15:0], unit_valid, string_end,           one result
//                 bad_input, unit_total[15:0]
//
// A byte is decoded in the cycle it is taken and its results are written
// into a result queue of FIFO_DEPTH entries, so a byte can be taken every
// cycle while the queue has room. The output side moves one result per
// cycle while o_out.ready is high, so a byte that ends a supplementary
// character yields two results. i_in.ready is high while the queue has
// room for two results. Reset is synchronous; it empties the queue.
// ----------------------------------------------------------------------------
module strict_utf8_to_utf16 #(
    parameter int FIFO_DEPTH = u8u16_pkg::RESULT_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u16_in_if.sink    i_in,
    u8u16_out_if.source o_out
);
    import u8u16_pkg::*;

    t_step   step;
    t_result head;
    logic    room;
    logic    head_valid;
    logic    take;

    assign i_in.ready = room;
    assign take       = i_in.valid && room;

    u8u16_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step_en (take),
        .i_byte    (i_in.in_byte),
        .i_last    (i_in.is_last),
        .o_step    (step)
    );

    u8u16_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_step  (step),
        .o_room  (room),
        .o_valid (head_valid),
        .o_data  (head),
        .i_pop   (o_out.ready)
    );

    assign o_out.valid      = head_valid;
    assign o_out.code_unit  = head.code_unit;
    assign o_out.unit_valid = head.unit_valid;
    assign o_out.string_end = head.string_end;
    assign o_out.bad_input  = head.bad_input;
    assign o_out.unit_total = head.unit_total;

    // The input only stalls while results are waiting.
    a_stall_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with an empty result queue");

    // A result without a unit is only the end-of-string report.
    a_empty_result_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.unit_valid) |-> (o_out.string_end && o_out.code_unit == 16'd0))
        else $error("result without a unit is not a clean end report");

    // A high surrogate never ends the string.
    a_high_surrogate_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.unit_valid && o_out.code_unit[15:10] == 6'b110110)
            |-> !o_out.string_end)
        else $error("string ended on a high surrogate");

    // A delivered unit is always counted.
    a_unit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.unit_valid) |-> (o_out.unit_total != 16'd0))
        else $error("unit delivered with a zero unit count");

endmodule
